// ----- hdl/itoa_pkg.sv -----
// ----------------------------------------------------------------------------
// itoa_pkg
// Constants shared by the integer to ascii digit converter: field widths,
// character codes and radix limits.
// ----------------------------------------------------------------------------
package itoa_pkg;

    localparam int VALUE_W   = 32;
    localparam int PAD_W     = 6;
    localparam int CHAR_W    = 8;
    localparam int RADIX_W   = 4;
    localparam int DIGIT_W   = 4;

    // bits of the magnitude consumed by the divider in one cycle
    localparam int BITS_PER_STEP = 8;
    localparam int STEPS         = VALUE_W / BITS_PER_STEP;
    localparam int STEP_W        = $clog2(STEPS);

    localparam int MAX_DIGITS_DEFAULT = 32;

    localparam logic [CHAR_W-1:0]  CHAR_ZERO     = 8'd48;
    localparam logic [CHAR_W-1:0]  CHAR_MINUS    = 8'd45;
    localparam logic [RADIX_W-1:0] DEFAULT_RADIX = 4'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN     = 4'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX     = 4'd10;

endpackage

// ----- hdl/integer_to_ascii_digits.sv -----
// ----------------------------------------------------------------------------
// integer_to_ascii_digits
// Converts a signed 32-bit value to an ascii digit string in a radix of 2 to
// 10, zero padded to a minimum digit count, sent one character per transfer.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  input    | in_valid, in_ready, value, min_digits     | in
//  output   | out_valid, out_ready, char_code, last     | out
//  config   | cfg_wen, cfg_wdata (radix)                | in
//
//  The divider is one remainder chain that takes 8 bits of the magnitude per
//  cycle, each digit being one pass over all 32 bits. Each digit character
//  then goes through the digit memory read port (S_READ, then S_LOAD) and the
//  sign through S_SIGN, held while out_ready is low; in_ready is high only between items.
//  rst_n clears the sequencer, the output valid and sets the radix to ten.
// ----------------------------------------------------------------------------
module integer_to_ascii_digits #(
    parameter int MAX_DIGITS = itoa_pkg::MAX_DIGITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wen,
    input  logic [itoa_pkg::RADIX_W-1:0]        cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [itoa_pkg::VALUE_W-1:0] value,
    input  logic [itoa_pkg::PAD_W-1:0]          min_digits,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [itoa_pkg::CHAR_W-1:0]         char_code,
    output logic                                last
);

    localparam int DEPTH = (MAX_DIGITS > itoa_pkg::VALUE_W) ? MAX_DIGITS : itoa_pkg::VALUE_W;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_SIGN = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_LOAD = 3'd4;

    logic [2:0]                         state_reg, state_next;
    logic [itoa_pkg::RADIX_W-1:0]       radix_reg;
    logic [itoa_pkg::RADIX_W-1:0]       eff_radix;
    logic [itoa_pkg::STEP_W-1:0]        step_reg, step_next;
    logic [IDX_W-1:0]                   digit_idx_reg, digit_idx_next;
    logic [itoa_pkg::VALUE_W-1:0]       work_reg, work_next;
    logic [itoa_pkg::DIGIT_W-1:0]       rem_reg, rem_next;
    logic                               neg_reg, neg_next;
    logic [CNT_W-1:0]                   pad_reg, pad_next;
    logic                               out_valid_reg, out_valid_next;
    logic [itoa_pkg::CHAR_W-1:0]        char_reg, char_next;
    logic                               last_reg, last_next;

    logic [itoa_pkg::DIGIT_W-1:0]       digit_mem [DEPTH];
    logic [itoa_pkg::DIGIT_W-1:0]       rd_data_reg;
    logic                               mem_wen;

    logic [itoa_pkg::VALUE_W-1:0]       div_quo;
    logic [itoa_pkg::DIGIT_W-1:0]       div_rem;
    logic [itoa_pkg::VALUE_W-1:0]       raw_value;
    logic [itoa_pkg::VALUE_W-1:0]       magnitude;
    logic [CNT_W-1:0]                   pad_in;
    logic [CNT_W-1:0]                   next_count;
    logic                               in_xfer;
    logic                               slot_free;

    // radix codes outside 2..10 are clamped
    always_comb
    begin
        if (radix_reg < itoa_pkg::RADIX_MIN)
            eff_radix = itoa_pkg::RADIX_MIN;
        else if (radix_reg > itoa_pkg::RADIX_MAX)
            eff_radix = itoa_pkg::RADIX_MAX;
        else
            eff_radix = radix_reg;
    end

    // shared divider: one restoring remainder step per magnitude bit
    always_comb
    begin
        logic [itoa_pkg::DIGIT_W-1:0]   r_v;
        logic [itoa_pkg::DIGIT_W:0]     t_v;
        logic [itoa_pkg::VALUE_W-1:0]   w_v;
        r_v = rem_reg;
        w_v = work_reg;
        t_v = '0;
        for (int b = 0; b < itoa_pkg::BITS_PER_STEP; b++)
        begin
            t_v = {r_v, w_v[itoa_pkg::VALUE_W-1]};
            w_v = {w_v[itoa_pkg::VALUE_W-2:0], 1'b0};
            if (t_v >= {1'b0, eff_radix})
            begin
                t_v    = t_v - {1'b0, eff_radix};
                w_v[0] = 1'b1;
            end
            r_v = t_v[itoa_pkg::DIGIT_W-1:0];
        end
        div_quo = w_v;
        div_rem = r_v;
    end

    assign raw_value  = $unsigned(value);
    assign magnitude  = raw_value[itoa_pkg::VALUE_W-1] ? (~raw_value + 32'd1) : raw_value;
    assign pad_in     = (CNT_W'(min_digits) > CNT_W'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS)
                                                                  : CNT_W'(min_digits);
    assign next_count = CNT_W'(digit_idx_reg) + CNT_W'(1);
    assign in_ready   = (state_reg == S_IDLE);
    assign in_xfer    = in_valid && in_ready;
    assign slot_free  = !out_valid_reg || out_ready;
    assign mem_wen    = (state_reg == S_DIV) &&
                        (step_reg == itoa_pkg::STEP_W'(itoa_pkg::STEPS - 1));

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        digit_idx_next = digit_idx_reg;
        work_next      = work_reg;
        rem_next       = rem_reg;
        neg_next       = neg_reg;
        pad_next       = pad_reg;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    work_next      = magnitude;
                    rem_next       = '0;
                    neg_next       = raw_value[itoa_pkg::VALUE_W-1];
                    pad_next       = pad_in;
                    step_next      = '0;
                    digit_idx_next = '0;
                    state_next     = S_DIV;
                end
            end
            S_DIV:
            begin
                work_next = div_quo;
                rem_next  = div_rem;
                step_next = step_reg + itoa_pkg::STEP_W'(1);
                if (mem_wen)
                begin
                    rem_next = '0;
                    // keep dividing while the quotient is nonzero or padding remains
                    if ((div_quo != '0) || (next_count < pad_reg))
                        digit_idx_next = digit_idx_reg + IDX_W'(1);
                    else if (neg_reg)
                        state_next = S_SIGN;
                    else
                        state_next = S_READ;
                end
            end
            S_SIGN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = itoa_pkg::CHAR_MINUS;
                    last_next      = 1'b0;
                    state_next     = S_READ;
                end
            end
            S_READ:
            begin
                // digit memory read data is registered into rd_data_reg for S_LOAD
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = itoa_pkg::CHAR_ZERO + itoa_pkg::CHAR_W'(rd_data_reg);
                    last_next      = (digit_idx_reg == '0);
                    if (digit_idx_reg == '0)
                        state_next = S_IDLE;
                    else
                    begin
                        digit_idx_next = digit_idx_reg - IDX_W'(1);
                        state_next     = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            radix_reg     <= itoa_pkg::DEFAULT_RADIX;
            step_reg      <= '0;
            digit_idx_reg <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            digit_idx_reg <= digit_idx_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wen)
                radix_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        neg_reg  <= neg_next;
        pad_reg  <= pad_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    // digit store, least significant digit at index zero
    always_ff @(posedge clk)
    begin
        if (mem_wen)
            digit_mem[digit_idx_reg] <= div_rem;
        rd_data_reg <= digit_mem[digit_idx_reg];
    end

    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign last      = last_reg;

`ifndef SYNTHESIS
    a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_DIV)
        else $error("accepted item did not start the divider");

    a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> rem_reg < eff_radix)
        else $error("partial remainder not below radix");

    a_more_chars_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> state_reg != S_IDLE)
        else $error("non-final character left with sequencer idle");

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (char_code == itoa_pkg::CHAR_MINUS) ||
                      ((char_code >= itoa_pkg::CHAR_ZERO) &&
                       (char_code < itoa_pkg::CHAR_ZERO + itoa_pkg::CHAR_W'(eff_radix))))
        else $error("character outside sign and digit range");
`endif

endmodule

// ----- dv/tb_integer_to_ascii_digits.sv -----
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_digits
// Self-checking bench for the integer to ascii digit converter. Numbers are
// pushed in bursts with random gaps, characters are pulled under a changing
// stall pattern. Every transfer is compared with a local conversion model.
// The radix is rewritten between phases, including the clamped codes.
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_digits;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIGITS       = itoa_pkg::MAX_DIGITS_DEFAULT;
    localparam int CLK_HALF         = 4;
    localparam int RESET_CYCLES     = 8;
    localparam int RANDOM_PER_PHASE = 45;
    localparam int IDLE_LIMIT       = 4000;
    localparam int SETTLE_CYCLES    = 4;
    localparam int TAIL_CYCLES      = 40;
    localparam int MAX_PRINTED      = 40;
    localparam int DIGIT_SLOTS      = 64;

    typedef struct {
        logic [itoa_pkg::VALUE_W-1:0] num;
        logic [itoa_pkg::PAD_W-1:0]   pad;
    } conv_item_t;

    typedef struct {
        logic [itoa_pkg::CHAR_W-1:0] code;
        logic                        is_last;
    } char_exp_t;

    logic                                clk        = 1'b0;
    logic                                rst_n      = 1'b0;
    logic                                cfg_wen    = 1'b0;
    logic [itoa_pkg::RADIX_W-1:0]        cfg_wdata  = '0;
    logic                                in_valid   = 1'b0;
    logic                                in_ready;
    logic signed [itoa_pkg::VALUE_W-1:0] value      = '0;
    logic [itoa_pkg::PAD_W-1:0]          min_digits = '0;
    logic                                out_valid;
    logic                                out_ready  = 1'b0;
    logic [itoa_pkg::CHAR_W-1:0]         char_code;
    logic                                last;

    conv_item_t pending_numbers[$];
    char_exp_t  expected_chars[$];
    char_exp_t  char_want;

    logic [itoa_pkg::RADIX_W-1:0] radix_model = itoa_pkg::DEFAULT_RADIX;

    int err_count      = 0;
    int chars_checked  = 0;
    int numbers_sent   = 0;
    int radix_settings = 1;
    int idle_cycles    = 0;

    // sender burst state
    int burst_left = 1;
    int gap_left   = 0;

    // receiver stall state
    int stall_left    = 0;
    int stall_pct     = 0;
    int stall_max     = 1;
    int pattern_cycle = 0;

    integer_to_ascii_digits #(
        .MAX_DIGITS (MAX_DIGITS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .min_digits (min_digits),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .char_code  (char_code),
        .last       (last)
    );

    always #CLK_HALF clk = ~clk;

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_PRINTED)
        begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        err_count++;
    endtask

    // expected character string of one number under the current radix
    function automatic void predict_digits(input logic [itoa_pkg::VALUE_W-1:0] raw,
                                           input logic [itoa_pkg::PAD_W-1:0]   pad_in);
        logic [itoa_pkg::CHAR_W-1:0]  digit_buf [DIGIT_SLOTS];
        logic [itoa_pkg::VALUE_W-1:0] mag;
        logic [itoa_pkg::VALUE_W-1:0] base;
        logic                         neg;
        int                           pad;
        int                           count;
        char_exp_t                    c;
        if (radix_model < itoa_pkg::RADIX_MIN)
            base = itoa_pkg::VALUE_W'(itoa_pkg::RADIX_MIN);
        else if (radix_model > itoa_pkg::RADIX_MAX)
            base = itoa_pkg::VALUE_W'(itoa_pkg::RADIX_MAX);
        else
            base = itoa_pkg::VALUE_W'(radix_model);
        neg = raw[itoa_pkg::VALUE_W-1];
        // unsigned magnitude, so the most negative number stays exact
        mag = neg ? (~raw + 1'b1) : raw;
        pad = int'(pad_in);
        if (pad > MAX_DIGITS)
            pad = MAX_DIGITS;
        count = 0;
        do
        begin
            digit_buf[count] = itoa_pkg::CHAR_ZERO + itoa_pkg::CHAR_W'(mag % base);
            count++;
            mag = mag / base;
        end
        while (count < DIGIT_SLOTS && (mag != 0 || count < pad));
        if (neg)
        begin
            c.code    = itoa_pkg::CHAR_MINUS;
            c.is_last = 1'b0;
            expected_chars.push_back(c);
        end
        for (int k = count - 1; k >= 0; k--)
        begin
            c.code    = digit_buf[k];
            c.is_last = (k == 0);
            expected_chars.push_back(c);
        end
    endfunction

    task automatic push_item(input logic [itoa_pkg::VALUE_W-1:0] num, input int pad);
        conv_item_t it;
        it.num = num;
        it.pad = itoa_pkg::PAD_W'(pad);
        pending_numbers.push_back(it);
    endtask

    task automatic load_random(input int n);
        conv_item_t it;
        int         sel;
        for (int k = 0; k < n; k++)
        begin
            sel = $urandom_range(0, 9);
            case (sel)
                0, 1, 2: it.num = $urandom;
                3, 4:    it.num = $urandom_range(0, 1000);
                5:       it.num = 32'd0 - itoa_pkg::VALUE_W'($urandom_range(1, 1000));
                6, 7:
                begin
                    it.num = $urandom >> $urandom_range(1, 31);
                    if ($urandom_range(0, 1) == 1)
                        it.num = 32'd0 - it.num;
                end
                default:
                begin
                    case ($urandom_range(0, 5))
                        0:       it.num = 32'h8000_0000;
                        1:       it.num = 32'h7fff_ffff;
                        2:       it.num = 32'hffff_ffff;
                        3:       it.num = 32'h0000_0000;
                        4:       it.num = 32'h0000_0001;
                        default: it.num = 32'h8000_0001;
                    endcase
                end
            endcase
            sel = $urandom_range(0, 19);
            if (sel < 12)
                it.pad = itoa_pkg::PAD_W'($urandom_range(0, 12));
            else if (sel < 17)
                it.pad = itoa_pkg::PAD_W'($urandom_range(0, 63));
            else
                it.pad = itoa_pkg::PAD_W'($urandom_range(30, 40));
            pending_numbers.push_back(it);
        end
    endtask

    task automatic wait_drained();
        while (pending_numbers.size() != 0 || in_valid || expected_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            value      <= '0;
            min_digits <= '0;
            burst_left = 1;
            gap_left   = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_digits(value, min_digits);
                numbers_sent++;
                burst_left--;
                if (burst_left <= 0)
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: gap_left = 0;
                        4, 5, 6:    gap_left = $urandom_range(1, 8);
                        default:    gap_left = $urandom_range(9, 180);
                    endcase
                    burst_left = $urandom_range(1, 10);
                end
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_numbers.size() != 0)
                begin
                    in_valid   <= 1'b1;
                    value      <= pending_numbers[0].num;
                    min_digits <= pending_numbers[0].pad;
                    void'(pending_numbers.pop_front());
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                chars_checked++;
                if (expected_chars.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected char 0x%02h last %0b",
                                              char_code, last));
                end
                else
                begin
                    char_want = expected_chars.pop_front();
                    if (char_code !== char_want.code)
                        report_mismatch($sformatf("char_code 0x%02h, want 0x%02h",
                                                  char_code, char_want.code));
                    if (last !== char_want.is_last)
                        report_mismatch($sformatf("last %0b, want %0b on char 0x%02h",
                                                  last, char_want.is_last, char_want.code));
                end
            end
            pattern_cycle++;
            if (pattern_cycle >= 256)
            begin
                pattern_cycle = 0;
                case ($urandom_range(0, 3))
                    0:       begin stall_pct = 0;  stall_max = 1;  end
                    1:       begin stall_pct = 20; stall_max = 2;  end
                    2:       begin stall_pct = 50; stall_max = 4;  end
                    default: begin stall_pct = 8;  stall_max = 30; end
                endcase
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 99) < stall_pct)
                    stall_left = $urandom_range(1, stall_max);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles + 1 >= IDLE_LIMIT)
        begin
            $display("watchdog: %0d cycles without a transfer", IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        logic [itoa_pkg::RADIX_W-1:0] radix_plan [9];
        radix_plan = '{4'd2, 4'd0, 4'd15, 4'd7, 4'd1, 4'd11, 4'd3, 4'd10, 4'd5};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed numbers at the reset radix of ten
        push_item(32'd0, 0);
        push_item(32'd0, 1);
        push_item(32'd0, 32);
        push_item(32'd0, 63);
        push_item(32'd1, 0);
        push_item(32'hffff_ffff, 0);
        push_item(32'd9, 0);
        push_item(32'd10, 0);
        push_item(32'd0 - 32'd10, 3);
        push_item(32'd123, 10);
        push_item(32'h8000_0000, 0);
        push_item(32'h7fff_ffff, 0);
        push_item(32'h8000_0000, 33);
        push_item(32'h7fff_ffff, 63);
        push_item(32'h8000_0001, 0);
        push_item(32'd1, 32);
        push_item(32'd0 - 32'd7, 31);
        push_item(32'h5555_5555, 6);
        push_item(32'haaaa_aaaa, 21);
        push_item(32'd999_999_999, 0);
        push_item(32'd1_000_000_000, 12);
        push_item(32'd0 - 32'd1_000_000_000, 0);
        load_random(RANDOM_PER_PHASE);
        wait_drained();

        for (int p = 0; p < 9; p++)
        begin
            @(posedge clk);
            cfg_wen     <= 1'b1;
            cfg_wdata   <= radix_plan[p];
            radix_model = radix_plan[p];
            @(posedge clk);
            cfg_wen <= 1'b0;
            radix_settings++;
            load_random(RANDOM_PER_PHASE);
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_chars.size() != 0)
            report_mismatch($sformatf("%0d characters never arrived", expected_chars.size()));

        $display("converted %0d numbers under %0d radix settings, clamped codes included",
                 numbers_sent, radix_settings);
        $display("%0d characters compared, %0d mismatches", chars_checked, err_count);
        if (err_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
